FILE: src/aes_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AES-128 package
// Shared types, constants and round functions for the AES-128 encrypt pipe.
// ---------------------------------------------------------------------------
package aes_pkg;

   localparam int ROUNDS = 10;
   localparam int BLOCK_W = 128;
   localparam int HALF_W = 64;

   // configuration register indexes
   localparam logic REG_KEY_HIGH = 1'b0;
   localparam logic REG_KEY_LOW  = 1'b1;

   // state word plus the round key that goes with it
   typedef struct packed {
      logic [BLOCK_W-1:0] state;
      logic [BLOCK_W-1:0] rkey;
   } stage_type;

   localparam logic [7:0] RCON [0:ROUNDS-1] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] SBOX [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block sits at bits 127-8i downto 120-8i
   function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX[s[BLOCK_W-1-8*(4*((c+r)%4)+r) -: 8]];
         end
      end
      sub_shift = t;
   endfunction

   function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] t;
      logic [7:0] a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0  = s[BLOCK_W-1-32*c -: 8];
         a1  = s[BLOCK_W-9-32*c -: 8];
         a2  = s[BLOCK_W-17-32*c -: 8];
         a3  = s[BLOCK_W-25-32*c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[BLOCK_W-1-32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                    a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
      end
      mix_columns = t;
   endfunction

   // one step of the key schedule: four words in, next four words out
   function automatic logic [BLOCK_W-1:0] next_key(input logic [BLOCK_W-1:0] k,
                                                    input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      t  = t ^ {rc, 24'h000000};
      n0 = w0 ^ t;
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
      next_key = {n0, n1, n2, n3};
   endfunction

endpackage

FILE: src/aes_chan_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AES block channels
// Valid/ready channels for plaintext words in and ciphertext words out.
// ---------------------------------------------------------------------------
interface aes_req_chan;
   logic        valid;
   logic        ready;
   logic [63:0] plain_high;
   logic [63:0] plain_low;

   modport source (output valid, output plain_high, output plain_low, input ready);
   modport sink   (input valid, input plain_high, input plain_low, output ready);
endinterface

interface aes_rsp_chan;
   logic        valid;
   logic        ready;
   logic [63:0] cipher_high;
   logic [63:0] cipher_low;

   modport source (output valid, output cipher_high, output cipher_low, input ready);
   modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

FILE: src/aes_round.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AES round stage
// One registered cipher round with its key schedule step alongside.
// ---------------------------------------------------------------------------
module aes_round (
   input  logic                clock,
   input  logic                reset,
   input  logic                final_round,
   input  logic [7:0]          rcon,
   input  logic                in_valid,
   input  aes_pkg::stage_type  in_word,
   input  logic                out_ready,
   output logic                in_ready,
   output logic                out_valid,
   output aes_pkg::stage_type  out_word
);

   logic                     valid_ff;
   aes_pkg::stage_type       word_ff;
   aes_pkg::stage_type       word_in;
   logic [aes_pkg::BLOCK_W-1:0] shifted;
   logic [aes_pkg::BLOCK_W-1:0] mixed;

   // stage register may take a new word when empty or when draining
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shifted       = aes_pkg::sub_shift(in_word.state);
      mixed         = final_round ? shifted : aes_pkg::mix_columns(shifted);
      word_in.rkey  = aes_pkg::next_key(in_word.rkey, rcon);
      word_in.state = mixed ^ word_in.rkey;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

FILE: src/aes128_block_encrypt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AES-128 block encrypt
// Fully unrolled AES-128 encryption, ECB, key from two config registers.
// ---------------------------------------------------------------------------
// Pipeline: 11 stage registers (key add + 10 rounds) from req accept to rsp valid.
// Throughput: one word per cycle while rsp ready stays high; each round stage holds one block.
// Stalls: each stage fills while empty, so bubbles close up under backpressure.
// Reset: stage valid bits cleared, key registers return to all-zero.
// ---------------------------------------------------------------------------
module aes128_block_encrypt (
   input  logic                 clock,
   input  logic                 reset,
   aes_req_chan.sink            req_chan,
   aes_rsp_chan.source          rsp_chan,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [63:0]          csr_wdata
);

   localparam int NSTAGE = aes_pkg::ROUNDS + 1;

   // key registers; the user must write them only while the pipe is empty (not enforced here)
   logic [63:0] key_high_ff;
   logic [63:0] key_low_ff;

   // stage 0 holds plaintext ^ key and the cipher key itself;
   // stage r holds the state after round r and round key r
   logic               valid [0:NSTAGE-1];
   aes_pkg::stage_type word  [0:NSTAGE-1];
   logic               ready [0:NSTAGE];

   logic               valid0_ff;
   aes_pkg::stage_type word0_ff;
   aes_pkg::stage_type word0_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            aes_pkg::REG_KEY_HIGH: key_high_ff <= csr_wdata;
            aes_pkg::REG_KEY_LOW:  key_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // initial round key add
   always_comb begin
      word0_in.rkey  = {key_high_ff, key_low_ff};
      word0_in.state = {req_chan.plain_high, req_chan.plain_low} ^ word0_in.rkey;
   end

   assign ready[0] = !valid0_ff || ready[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (ready[0]) begin
         valid0_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0] && req_chan.valid) begin
         word0_ff <= word0_in;
      end
   end

   assign valid[0]       = valid0_ff;
   assign word[0]        = word0_ff;
   assign req_chan.ready = ready[0];

   // ten round stages, the last one skips MixColumns
   for (genvar g = 1; g < NSTAGE; g++) begin : g_round
      aes_round u_round (
         .clock       (clock),
         .reset       (reset),
         .final_round (g == aes_pkg::ROUNDS),
         .rcon        (aes_pkg::RCON[g-1]),
         .in_valid    (valid[g-1]),
         .in_word     (word[g-1]),
         .out_ready   (ready[g+1]),
         .in_ready    (ready[g]),
         .out_valid   (valid[g]),
         .out_word    (word[g])
      );
   end

   // last stage register doubles as the output register
   assign ready[NSTAGE]        = rsp_chan.ready;
   assign rsp_chan.valid       = valid[NSTAGE-1];
   assign rsp_chan.cipher_high = word[NSTAGE-1].state[127:64];
   assign rsp_chan.cipher_low  = word[NSTAGE-1].state[63:0];

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AES-128 block encrypt testbench
// Pushes plaintext words through the encrypt pipe under several keys and
// checks every ciphertext word against an independent AES-128 model kept
// in the bench, with random idle on the sending side and random stalls on
// the receiving side.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int NUM_ROUNDS  = 10;
   localparam int STUCK_LIMIT = 2000;   // cycles with no word moving on either side
   localparam int MAX_REPORTS = 40;
   localparam int HOLD_LEN    = 80;     // cycles of the long receiver hold-off

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } aes_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_wr_en;
   logic        csr_index;
   logic [63:0] csr_wdata;

   aes_req_chan req_if ();
   aes_rsp_chan rsp_if ();

   aes128_block_encrypt dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // bench copy of the key registers; only changed while the pipe is empty
   logic [127:0] key_model;
   logic [7:0]   sub_lut [0:255];

   aes_word_type plain_backlog [$];   // words waiting for the driver
   aes_word_type ciphers_due [$];     // ciphertexts owed by the pipe, oldest first

   int queued_count  = 0;          // plaintext words handed to the driver
   int checked_count = 0;          // ciphertext words matched to an expectation
   int error_count   = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   logic hold_rsp  = 1'b0;         // long receiver hold-off
   logic hold_req  = 1'b0;         // sequence asks for the hold-off
   logic hold_done = 1'b0;
   int hold_cycles = 0;
   int stuck_cycles = 0;

   // ---------------------------------------------------------------------
   // GF(2^8) helpers and the AES-128 model
   // ---------------------------------------------------------------------
   function automatic logic [7:0] gf_dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = gf_dbl(a);
         b = b >> 1;
      end
      return p;
   endfunction

   // S-box built from the field inverse plus the affine map, not from a table
   task automatic build_sub_lut();
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++) begin
            if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         end
         sub_lut[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                      ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      end
   endtask

   // state byte i = row i%4, column i/4; byte 0 is the top byte of the word
   function automatic aes_word_type encrypt_block(input logic [127:0] key,
                                                  input aes_word_type plain);
      logic [31:0]  w [0:4*NUM_ROUNDS+3];
      logic [7:0]   s [0:15];
      logic [7:0]   t [0:15];
      logic [31:0]  tmp;
      logic [7:0]   rc, a0, a1, a2, a3;
      logic [127:0] flat;
      flat = {plain.high, plain.low};
      for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
      rc = 8'h01;
      for (int i = 4; i < 4*NUM_ROUNDS+4; i++) begin
         tmp = w[i-1];
         if (i % 4 == 0) begin
            // rotate, substitute, fold in the round constant
            tmp = {sub_lut[tmp[23:16]], sub_lut[tmp[15:8]], sub_lut[tmp[7:0]],
                   sub_lut[tmp[31:24]]} ^ {rc, 24'h000000};
            rc = gf_dbl(rc);
         end
         w[i] = w[i-4] ^ tmp;
      end
      for (int i = 0; i < 16; i++) s[i] = flat[127-8*i -: 8] ^ w[i/4][31-8*(i%4) -: 8];
      for (int rnd = 1; rnd <= NUM_ROUNDS; rnd++) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) t[4*c+r] = sub_lut[s[4*((c+r)%4)+r]];
         end
         if (rnd != NUM_ROUNDS) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               s[4*c]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
               s[4*c+1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
               s[4*c+2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
               s[4*c+3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
            end
         end else begin
            for (int i = 0; i < 16; i++) s[i] = t[i];
         end
         for (int i = 0; i < 16; i++) s[i] ^= w[4*rnd + i/4][31-8*(i%4) -: 8];
      end
      for (int i = 0; i < 16; i++) flat[127-8*i -: 8] = s[i];
      return flat;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t ns: %s mismatch: got %h want %h", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Driver: one plaintext word on offer at a time, held until taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_plain
      aes_word_type blk;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         // the word on offer was just taken: its ciphertext is now owed
         if (req_if.valid && req_if.ready)
            ciphers_due = {ciphers_due,
                           encrypt_block(key_model, {req_if.plain_high, req_if.plain_low})};
         if (!req_if.valid || req_if.ready) begin
            if (plain_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               blk = plain_backlog.pop_front();
               req_if.valid      <= 1'b1;
               req_if.plain_high <= blk.high;
               req_if.plain_low  <= blk.low;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random backpressure, compare each ciphertext word in order
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_cipher
      aes_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (ciphers_due.size() == 0) begin
               report_mismatch("unexpected word, cipher_high", rsp_if.cipher_high, 64'h0);
            end else begin
               want = ciphers_due.pop_front();
               if (rsp_if.cipher_high !== want.high)
                  report_mismatch("cipher_high", rsp_if.cipher_high, want.high);
               if (rsp_if.cipher_low !== want.low)
                  report_mismatch("cipher_low", rsp_if.cipher_low, want.low);
               checked_count++;
            end
         end
         rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off, counted here once the sequence asks for it
   always @(posedge clock) begin : hold_off
      if (reset) begin
         hold_rsp    <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_req && !hold_done) begin
         if (hold_cycles < HOLD_LEN) begin
            hold_rsp    <= 1'b1;
            hold_cycles <= hold_cycles + 1;
         end else begin
            hold_rsp  <= 1'b0;
            hold_done <= 1'b1;
         end
      end
   end

   // Watchdog: a hung pipe shows up as a long run with no word moving
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencing helpers
   // ---------------------------------------------------------------------
   task automatic queue_plain(input logic [63:0] high, input logic [63:0] low);
      aes_word_type blk;
      blk = {high, low};
      plain_backlog = {plain_backlog, blk};
      queued_count++;
   endtask

   task automatic queue_random(input int count);
      repeat (count) queue_plain({$urandom, $urandom}, {$urandom, $urandom});
   endtask

   // every queued word has come back, so the pipe is empty
   task automatic wait_drained();
      wait (checked_count == queued_count);
      @(posedge clock);
   endtask

   task automatic write_key_reg(input logic idx, input logic [63:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == aes_pkg::REG_KEY_HIGH) key_model[127:64] = data;
      else                              key_model[63:0]   = data;
   endtask

   task automatic load_key(input logic [127:0] key);
      write_key_reg(aes_pkg::REG_KEY_HIGH, key[127:64]);
      write_key_reg(aes_pkg::REG_KEY_LOW, key[63:0]);
   endtask

   task automatic set_idling(input int idle_pct, input int stall_pct);
      @(posedge clock);
      send_idle_pct  <= idle_pct;
      recv_stall_pct <= stall_pct;
   endtask

   task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
      load_key({$urandom, $urandom, $urandom, $urandom});
      set_idling(idle_pct, stall_pct);
      queue_random(count);
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      req_if.valid      = 1'b0;
      req_if.plain_high = '0;
      req_if.plain_low  = '0;
      rsp_if.ready      = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = aes_pkg::REG_KEY_HIGH;
      csr_wdata         = '0;
      key_model         = '0;
      build_sub_lut();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // key never written: reset value of all zeros applies
      queue_plain(64'h0, 64'h0);
      queue_plain('1, '1);
      queue_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
      queue_plain(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      queue_plain(64'h8000000000000000, 64'h0000000000000001);
      wait_drained();

      // all-ones key
      load_key('1);
      queue_plain(64'h0, 64'h0);
      queue_plain('1, '1);
      queue_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
      wait_drained();

      // standard known-answer key, plus edge plaintexts
      load_key(128'h000102030405060708090a0b0c0d0e0f);
      queue_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
      queue_plain(64'h0, 64'h0);
      queue_plain('1, '1);
      queue_plain(64'h0, 64'h0000000000000001);
      wait_drained();

      // only the upper key half changes; lower half must be kept
      write_key_reg(aes_pkg::REG_KEY_HIGH, 64'h0);
      queue_plain(64'hffffffffffffffff, 64'h0);
      queue_plain(64'h0123456789abcdef, 64'hfedcba9876543210);
      wait_drained();

      // explicit all-zero key
      load_key('0);
      queue_plain(64'h0, 64'h0);
      queue_plain('1, '1);
      wait_drained();

      // random words under random keys, one idling style per phase
      random_phase(240, 0, 0);
      random_phase(220, 86, 0);
      random_phase(220, 0, 86);
      random_phase(240, 28, 28);

      // receiver holds off while the sender keeps offering: pipe fills and
      // must stall its input without losing or reordering anything
      load_key({$urandom, $urandom, $urandom, $urandom});
      set_idling(0, 0);
      queue_random(60);
      hold_req <= 1'b1;
      wait (hold_done);
      wait_drained();

      // settle time covers pipe latency; catches stray extra words
      repeat (40) @(posedge clock);
      if (error_count == 0 && ciphers_due.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
